@@ rtl/bna_pkg.sv @@
// Shared types, action codes and the bus-constant function of the nibble ALU.
// No dependencies; imported by the core, the top level and the checker.
package bna_pkg;

	localparam int unsigned ItemDataW = 16;
	localparam int unsigned ItemUserW = 2;
	localparam int unsigned ResDataW  = 8;
	localparam int unsigned ResUserW  = 1;

	localparam logic [3:0] NIB_ONES  = 4'hF;
	localparam logic [3:0] DEC_LIMIT = 4'd9;
	localparam logic [3:0] DEC_FIX   = 4'd6;
	localparam logic [3:0] TCS_CONST = 4'd9;
	localparam logic [3:0] KBP_FOUR  = 4'd4;
	localparam logic [3:0] KBP_EIGHT = 4'd8;
	localparam logic [3:0] KBP_LOW   = 4'd2;
	localparam logic [3:0] KBP_ERR   = 4'd15;

	typedef enum logic [3:0] {
		ACT_INIT      = 4'd0,
		ACT_LATCH     = 4'd1,
		ACT_LOAD_TEMP = 4'd2,
		ACT_SET_A     = 4'd3,
		ACT_SET_C     = 4'd4,
		ACT_RUN_ADDER = 4'd5,
		ACT_DRV_CONST = 4'd6,
		ACT_DRV_ACC   = 4'd7,
		ACT_DRV_SUM   = 4'd8,
		ACT_DRV_CARRY = 4'd9
	} action_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_DAA   = 2'd1,
		KIND_TCS   = 2'd2,
		KIND_KBP   = 2'd3
	} instr_kind_t;

	typedef struct packed {
		logic [3:0]  action;
		logic [3:0]  bus_in;
		logic        invert_operand;
		logic        save_acc;
		logic        save_carry;
		logic        shift_left;
		logic        shift_right;
		logic        carry_force_one;
		instr_kind_t instr_kind;
		logic        opa_high;
	} item_t;

	typedef struct packed {
		logic [3:0] bus_out;
		logic       bus_drive;
		logic       acc_zero;
		logic       sum_zero;
		logic       carry_set;
	} result_t;

	// Bus constant for decimal adjust, TCS and KBP, all ones for other kinds; zero unless high.
	function automatic logic [3:0] bus_constant(input instr_kind_t kind, input logic high,
			input logic [3:0] acc_l, input logic carry_l);
		logic [3:0] c;
		c = '0;
		if (high) begin
			unique case (kind)
				KIND_DAA: c = (carry_l || (acc_l > DEC_LIMIT)) ? DEC_FIX : 4'd0;
				KIND_TCS: c = TCS_CONST;
				KIND_KBP: begin
					priority if (acc_l == KBP_FOUR) c = 4'd3;
					else if (acc_l == KBP_EIGHT) c = 4'd4;
					else if (acc_l > KBP_LOW) c = KBP_ERR;
					else c = acc_l;
				end
				default: c = NIB_ONES;
			endcase
		end
		return c;
	endfunction

endpackage

@@ rtl/bna_core.sv @@
// ALU state registers and the single-pass micro-operation logic.
// Depends on bna_pkg; instantiated by bcd_nibble_alu_micro_ops_top.
module bna_core
	import bna_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	output result_t res
);

	logic [3:0] acc_q, temp_q, adder_a_q, acc_lat_q, sum_q;
	logic       carry_q, cin_q, carry_lat_q;
	logic [3:0] acc_d, temp_d, adder_a_d, acc_lat_d, sum_d;
	logic       carry_d, cin_d, carry_lat_d;

	logic [3:0] operand_b;
	logic [4:0] sum_full;
	logic       dec_adjust;

	assign operand_b  = item.invert_operand ? ~temp_q : temp_q;
	assign sum_full   = {1'b0, adder_a_q} + {1'b0, operand_b} + {4'd0, cin_q};
	assign dec_adjust = carry_lat_q || (acc_lat_q > DEC_LIMIT);

	always_comb begin
		acc_d       = acc_q;
		temp_d      = temp_q;
		adder_a_d   = adder_a_q;
		acc_lat_d   = acc_lat_q;
		sum_d       = sum_q;
		carry_d     = carry_q;
		cin_d       = cin_q;
		carry_lat_d = carry_lat_q;
		res.bus_out   = '0;
		res.bus_drive = 1'b0;
		unique case (item.action)
			ACT_INIT: begin
				adder_a_d = '0;
				temp_d    = NIB_ONES;
				cin_d     = 1'b0;
			end
			ACT_LATCH: begin
				acc_lat_d   = acc_q;
				carry_lat_d = carry_q;
			end
			ACT_LOAD_TEMP: temp_d = item.bus_in;
			ACT_SET_A: adder_a_d = item.invert_operand ? ~acc_q : acc_q;
			ACT_SET_C: begin
				cin_d = item.carry_force_one | (carry_q ^ item.invert_operand);
			end
			ACT_RUN_ADDER: begin
				sum_d = sum_full[3:0];
				// left shift wins over right; either ignores the save flags
				priority if (item.shift_left) begin
					carry_d = sum_full[3];
					acc_d   = {sum_full[2:0], carry_lat_q};
				end else if (item.shift_right) begin
					carry_d = sum_full[0];
					acc_d   = {carry_lat_q, sum_full[3:1]};
				end else begin
					if (item.save_acc) acc_d = sum_full[3:0];
					if (item.save_carry) begin
						carry_d = ((item.instr_kind == KIND_DAA) && dec_adjust)
							? 1'b1 : sum_full[4];
					end
				end
			end
			ACT_DRV_CONST: begin
				res.bus_out   = bus_constant(item.instr_kind, item.opa_high,
					acc_lat_q, carry_lat_q);
				res.bus_drive = 1'b1;
			end
			ACT_DRV_ACC: begin
				res.bus_out   = acc_lat_q;
				res.bus_drive = 1'b1;
			end
			ACT_DRV_SUM: begin
				res.bus_out   = sum_q;
				res.bus_drive = 1'b1;
			end
			ACT_DRV_CARRY: begin
				res.bus_out   = {3'd0, carry_lat_q};
				res.bus_drive = 1'b1;
			end
			default: ;
		endcase
		// flags follow the state as this item leaves it
		res.acc_zero  = (acc_lat_d == 4'd0);
		res.sum_zero  = (sum_d == 4'd0);
		res.carry_set = carry_lat_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			temp_q      <= '0;
			adder_a_q   <= '0;
			acc_lat_q   <= '0;
			sum_q       <= '0;
			carry_q     <= 1'b0;
			cin_q       <= 1'b0;
			carry_lat_q <= 1'b0;
		end else if (en) begin
			acc_q       <= acc_d;
			temp_q      <= temp_d;
			adder_a_q   <= adder_a_d;
			acc_lat_q   <= acc_lat_d;
			sum_q       <= sum_d;
			carry_q     <= carry_d;
			cin_q       <= cin_d;
			carry_lat_q <= carry_lat_d;
		end
	end

endmodule

@@ rtl/bcd_nibble_alu_micro_ops_top.sv @@
// Top level of the 4-bit decimal-adjust ALU: input register, core, result register.
// Depends on bna_pkg and bna_core.
// An accepted item sits in the input register, then its result in the result register.
// One item per cycle unless m_tready stalls; state update sits between the two registers.
// Reset: arst_n low clears both valid bits and all ALU state to zero at once.
module bcd_nibble_alu_micro_ops_top
	import bna_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// action[3:0], bus_in[7:4], invert_operand[8], save_acc[9], save_carry[10],
	// shift_left[11], shift_right[12], carry_force_one[13], opa_high[14], zero[15]
	input  logic [ItemDataW-1:0] s_tdata,
	// instr_kind[1:0]
	input  logic [ItemUserW-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// bus_out[3:0], acc_zero[4], sum_zero[5], carry_set[6], zero[7]
	output logic [ResDataW-1:0]  m_tdata,
	// bus_drive[0]
	output logic [ResUserW-1:0]  m_tuser
);

	logic    valid_s1, valid_s2;
	item_t   item_s1, item_in;
	result_t res_s2, res_d;
	logic    adv_s2, adv_s1;

	assign item_in.action          = s_tdata[3:0];
	assign item_in.bus_in          = s_tdata[7:4];
	assign item_in.invert_operand  = s_tdata[8];
	assign item_in.save_acc        = s_tdata[9];
	assign item_in.save_carry      = s_tdata[10];
	assign item_in.shift_left      = s_tdata[11];
	assign item_in.shift_right     = s_tdata[12];
	assign item_in.carry_force_one = s_tdata[13];
	assign item_in.opa_high        = s_tdata[14];
	assign item_in.instr_kind      = instr_kind_t'(s_tuser[1:0]);

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	bna_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.item   (item_s1),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) item_s1 <= item_in;
		if (adv_s1) res_s2 <= res_d;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2.carry_set, res_s2.sum_zero, res_s2.acc_zero,
		res_s2.bus_out};
	assign m_tuser  = res_s2.bus_drive;

endmodule

@@ rtl/bna_checker.sv @@
// Port-level checker for the nibble ALU top level, bound to every instance.
// Depends on bna_pkg and bcd_nibble_alu_micro_ops_top.
module bna_checker
	import bna_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [ItemDataW-1:0] s_tdata,
	input logic [ItemUserW-1:0] s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [ResDataW-1:0]  m_tdata,
	input logic [ResUserW-1:0]  m_tuser
);

	// hold a stalled result
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// an empty result register must never block the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// the bus nibble is zero unless the action drives the bus
	a_bus_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[3:0] == 4'd0)
		else $error("bus nibble set without drive");

endmodule

bind bcd_nibble_alu_micro_ops_top bna_checker u_bna_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
